FILE: sv/pid_is_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_is_pkg
// Shared widths, register indexes and configuration type for the PID block.
// ----------------------------------------------------------------------------
package pid_is_pkg;

    localparam int GAIN_W     = 32;
    localparam int IN_W       = 16;
    localparam int ERR_W      = IN_W + 1;
    localparam int DIFF_W     = ERR_W + 1;
    localparam int LIM_W      = 15;
    localparam int THR_W      = 16;
    localparam int OUT_W      = 16;
    localparam int P_W        = GAIN_W + ERR_W;
    localparam int D_W        = GAIN_W + DIFF_W;
    localparam int PD_W       = D_W + 1;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [LIM_W-1:0] INT_LIM_RST = 15'd16384;
    localparam logic [LIM_W-1:0] OUT_LIM_RST = 15'd16384;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_GAIN_P   = 3'd0,
        REG_GAIN_I   = 3'd1,
        REG_GAIN_D   = 3'd2,
        REG_INT_LIM  = 3'd3,
        REG_OUT_LIM  = 3'd4,
        REG_SEP_THR  = 3'd5,
        REG_SEP_ON   = 3'd6,
        REG_POS_MODE = 3'd7
    } t_cfg_reg;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_p;
        logic [GAIN_W-1:0] gain_i;
        logic [GAIN_W-1:0] gain_d;
        logic [LIM_W-1:0]  int_lim;
        logic [LIM_W-1:0]  out_lim;
        logic [THR_W-1:0]  sep_thr;
        logic              sep_on;
        logic              pos_mode;
    } t_cfg;

endpackage

FILE: sv/pid_is_err_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_is_err_mul
// Error, error difference and the three gain products, registered.
// ----------------------------------------------------------------------------
module pid_is_err_mul
    import pid_is_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_load,
    input  t_cfg                   i_cfg,
    input  logic [IN_W-1:0]        i_target,
    input  logic [IN_W-1:0]        i_measured,
    output logic signed [P_W-1:0]  o_p,
    output logic signed [D_W-1:0]  o_d,
    output logic signed [P_W-1:0]  o_inc
);

    logic signed [ERR_W-1:0]  err;
    logic signed [DIFF_W-1:0] diff;
    logic [ERR_W-1:0]         mag;
    logic                     integ_en;
    logic signed [P_W-1:0]    p_prod;
    logic signed [D_W-1:0]    d_prod;
    logic signed [P_W-1:0]    i_prod;

    logic signed [ERR_W-1:0]  r_prev_err;
    logic signed [P_W-1:0]    r_p;
    logic signed [D_W-1:0]    r_d;
    logic signed [P_W-1:0]    r_inc;

    assign err  = $signed({i_target[IN_W-1], i_target})
                - $signed({i_measured[IN_W-1], i_measured});
    assign diff = $signed({err[ERR_W-1], err}) - $signed({r_prev_err[ERR_W-1], r_prev_err});
    assign mag  = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);

    // separation: when enabled, integrate only while |e| is strictly under the threshold
    assign integ_en = !i_cfg.sep_on || (mag < {1'b0, i_cfg.sep_thr});

    assign p_prod = P_W'($signed(i_cfg.gain_p)) * P_W'(err);
    assign d_prod = D_W'($signed(i_cfg.gain_d)) * D_W'(diff);
    assign i_prod = P_W'($signed(i_cfg.gain_i)) * P_W'(err);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_err <= '0;
        end else if (i_load) begin
            r_prev_err <= err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_p   <= p_prod;
            r_d   <= d_prod;
            r_inc <= integ_en ? i_prod : '0;
        end
    end

    assign o_p   = r_p;
    assign o_d   = r_d;
    assign o_inc = r_inc;

endmodule

FILE: sv/pid_is_integ.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_is_integ
// Integral accumulator with symmetric clamp; also adds the P and D terms.
// ----------------------------------------------------------------------------
module pid_is_integ
    import pid_is_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_load,
    input  t_cfg                              i_cfg,
    input  logic signed [P_W-1:0]             i_p,
    input  logic signed [D_W-1:0]             i_d,
    input  logic signed [P_W-1:0]             i_inc,
    output logic signed [LIM_W+FRAC_BITS:0]   o_integral,
    output logic signed [PD_W-1:0]            o_pd
);

    localparam int INT_W = LIM_W + FRAC_BITS + 1;
    localparam int ACC_W = P_W + 1;

    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] lim;
    logic signed [ACC_W-1:0] acc_clamped;

    logic signed [INT_W-1:0] r_integral;
    logic signed [PD_W-1:0]  r_pd;

    assign acc = ACC_W'(r_integral) + ACC_W'(i_inc);
    assign lim = ACC_W'($signed({1'b0, i_cfg.int_lim, {FRAC_BITS{1'b0}}}));

    always_comb begin
        priority if (acc > lim) begin
            acc_clamped = lim;
        end else if (acc < -lim) begin
            acc_clamped = -lim;
        end else begin
            acc_clamped = acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integral <= '0;
        end else if (i_load && i_cfg.pos_mode) begin
            r_integral <= acc_clamped[INT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pd <= PD_W'(i_p) + PD_W'(i_d);
        end
    end

    assign o_integral = r_integral;
    assign o_pd       = r_pd;

endmodule

FILE: sv/pid_is_drive.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_is_drive
// Final sum, output clamp and truncation toward zero into the drive register.
// ----------------------------------------------------------------------------
module pid_is_drive
    import pid_is_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_load,
    input  t_cfg                             i_cfg,
    input  logic signed [PD_W-1:0]           i_pd,
    input  logic signed [LIM_W+FRAC_BITS:0]  i_integral,
    output logic [OUT_W-1:0]                 o_drive
);

    localparam int SUM_W = PD_W + 1;

    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] lim;
    logic signed [SUM_W-1:0] sum_clamped;
    logic signed [SUM_W-1:0] adj;
    logic signed [SUM_W-1:0] shifted;

    logic [OUT_W-1:0] r_drive;

    assign sum = SUM_W'(i_pd) + SUM_W'(i_integral);
    assign lim = SUM_W'($signed({1'b0, i_cfg.out_lim, {FRAC_BITS{1'b0}}}));

    always_comb begin
        priority if (sum > lim) begin
            sum_clamped = lim;
        end else if (sum < -lim) begin
            sum_clamped = -lim;
        end else begin
            sum_clamped = sum;
        end
    end

    // bias negatives by one LSB short of a unit so the shift rounds toward zero
    assign adj = sum_clamped
               + $signed({{(SUM_W-FRAC_BITS){1'b0}}, {FRAC_BITS{sum_clamped[SUM_W-1]}}});
    assign shifted = adj >>> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_drive <= i_cfg.pos_mode ? shifted[OUT_W-1:0] : '0;
        end
    end

    assign o_drive = r_drive;

endmodule

FILE: sv/pid_integral_separation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_integral_separation
// Positional PID with integral separation, four-stage elastic pipeline.
// ----------------------------------------------------------------------------
// Four register stages: inputs, gain products, integral and P+D sum, drive.
// One item per cycle unless stalled; the integral add and clamp close in one stage.
// Stalls back up stage by stage; bubbles are squeezed out before o_stall rises.
// Reset (synchronous, active low) empties the pipeline, zeroes the error history
// and integral, and loads the register defaults.
module pid_integral_separation
    import pid_is_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [IN_W-1:0]         i_target_value,
    input  logic [IN_W-1:0]         i_measured_value,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [OUT_W-1:0]        o_drive_value,
    input  logic                    i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    t_cfg r_cfg;

    logic r_v1, r_v2, r_v3, r_v4;
    logic rdy1, rdy2, rdy3, rdy4;

    logic [IN_W-1:0] r_target;
    logic [IN_W-1:0] r_measured;

    logic signed [P_W-1:0]            p_term;
    logic signed [D_W-1:0]            d_term;
    logic signed [P_W-1:0]            i_step;
    logic signed [LIM_W+FRAC_BITS:0]  integral;
    logic signed [PD_W-1:0]           pd_sum;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p   <= '0;
            r_cfg.gain_i   <= '0;
            r_cfg.gain_d   <= '0;
            r_cfg.int_lim  <= INT_LIM_RST;
            r_cfg.out_lim  <= OUT_LIM_RST;
            r_cfg.sep_thr  <= '0;
            r_cfg.sep_on   <= 1'b0;
            r_cfg.pos_mode <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_addr))
                REG_GAIN_P:   r_cfg.gain_p   <= i_cfg_data[GAIN_W-1:0];
                REG_GAIN_I:   r_cfg.gain_i   <= i_cfg_data[GAIN_W-1:0];
                REG_GAIN_D:   r_cfg.gain_d   <= i_cfg_data[GAIN_W-1:0];
                REG_INT_LIM:  r_cfg.int_lim  <= i_cfg_data[LIM_W-1:0];
                REG_OUT_LIM:  r_cfg.out_lim  <= i_cfg_data[LIM_W-1:0];
                REG_SEP_THR:  r_cfg.sep_thr  <= i_cfg_data[THR_W-1:0];
                REG_SEP_ON:   r_cfg.sep_on   <= i_cfg_data[0];
                REG_POS_MODE: r_cfg.pos_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // a stage may take a new item if empty or if its item moves on this cycle
    assign rdy4 = !r_v4 || !i_stall;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;

    assign o_stall = !rdy1;
    assign o_valid = r_v4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
            if (rdy4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && rdy1) begin
            r_target   <= i_target_value;
            r_measured <= i_measured_value;
        end
    end

    pid_is_err_mul u_err_mul (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (r_v1 && rdy2),
        .i_cfg      (r_cfg),
        .i_target   (r_target),
        .i_measured (r_measured),
        .o_p        (p_term),
        .o_d        (d_term),
        .o_inc      (i_step)
    );

    pid_is_integ #(
        .FRAC_BITS (FRAC_BITS)
    ) u_integ (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (r_v2 && rdy3),
        .i_cfg      (r_cfg),
        .i_p        (p_term),
        .i_d        (d_term),
        .i_inc      (i_step),
        .o_integral (integral),
        .o_pd       (pd_sum)
    );

    pid_is_drive #(
        .FRAC_BITS (FRAC_BITS)
    ) u_drive (
        .i_clk      (i_clk),
        .i_load     (r_v3 && rdy4),
        .i_cfg      (r_cfg),
        .i_pd       (pd_sum),
        .i_integral (integral),
        .o_drive    (o_drive_value)
    );

`ifndef SYNTH
    // input only backs up once every stage holds an item and the sink stalls
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_v1 && r_v2 && r_v3 && r_v4 && i_stall))
        else $error("input stalled with a bubble in the pipeline");

    a_drive_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($signed(o_drive_value) <= $signed({1'b0, r_cfg.out_lim}) &&
                     $signed(o_drive_value) >= -$signed({1'b0, r_cfg.out_lim})))
        else $error("drive outside output limit");

    a_nonpos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !r_cfg.pos_mode) |-> (o_drive_value == '0))
        else $error("non-zero drive in non-positional mode");
`endif

endmodule

FILE: tb/tb_pid_integral_separation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pid_integral_separation
// Self-checking bench for the PID block with integral separation. A short
// table of directed samples and register writes comes first, then phases of
// random samples under random register settings. Every drive value is checked
// in order against its table value or a cycle-free model of error history and integral.
// ----------------------------------------------------------------------------
module tb_pid_integral_separation;
    import pid_is_pkg::*;

    localparam int FRAC_BITS = 16;
    localparam int N_PHASES  = 12;
    localparam int PHASE_LEN = 90;

    typedef struct {
        bit       is_cfg;
        t_cfg_reg idx;
        logic [CFG_DATA_W-1:0] data;
        int       tgt;
        int       meas;
        bit       typed;
        int       want;
    } t_plan_row;

    logic                  i_clk            = 1'b0;
    logic                  i_rst_n          = 1'b0;
    logic                  i_valid          = 1'b0;
    logic                  o_stall;
    logic [IN_W-1:0]       i_target_value   = '0;
    logic [IN_W-1:0]       i_measured_value = '0;
    logic                  o_valid;
    logic                  i_stall          = 1'b0;
    logic [OUT_W-1:0]      o_drive_value;
    logic                  i_cfg_we         = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr       = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data       = '0;

    // register mirror and block state as the model sees them
    t_cfg       cfg_mirror = '{gain_p: '0, gain_i: '0, gain_d: '0, int_lim: INT_LIM_RST,
                               out_lim: OUT_LIM_RST, sep_thr: '0, sep_on: 1'b0,
                               pos_mode: 1'b1};
    longint     err_hist  = 0;
    longint     integ_acc = 0;

    logic [OUT_W-1:0] drive_expected_q[$];
    int  fail_count = 0;
    int  stall_left = 0;
    bit  tx_calm    = 1'b0;
    bit  rx_calm    = 1'b0;

    t_plan_row directed_plan [40] = '{
        '{0, REG_GAIN_P,   0,             0,      0,      1, 0},
        '{0, REG_GAIN_P,   0,             32767,  -32768, 1, 0},
        '{0, REG_GAIN_P,   0,             -32768, 32767,  1, 0},
        '{1, REG_INT_LIM,  32767,         0,      0,      0, 0},
        '{1, REG_OUT_LIM,  32767,         0,      0,      0, 0},
        '{1, REG_GAIN_P,   32'h0001_0000, 0,      0,      0, 0},
        '{0, REG_GAIN_P,   0,             100,    0,      1, 100},
        '{0, REG_GAIN_P,   0,             32767,  -32768, 1, 32767},
        '{0, REG_GAIN_P,   0,             -32768, 32767,  1, -32767},
        '{1, REG_GAIN_P,   32'h0000_8000, 0,      0,      0, 0},
        '{0, REG_GAIN_P,   0,             3,      0,      1, 1},
        '{0, REG_GAIN_P,   0,             -3,     0,      1, -1},
        '{1, REG_OUT_LIM,  0,             0,      0,      0, 0},
        '{0, REG_GAIN_P,   0,             1000,   0,      1, 0},
        '{1, REG_OUT_LIM,  32767,         0,      0,      0, 0},
        '{1, REG_GAIN_P,   32'h8000_0000, 0,      0,      0, 0},
        '{0, REG_GAIN_P,   0,             1,      0,      1, -32767},
        '{1, REG_GAIN_P,   0,             0,      0,      0, 0},
        '{1, REG_GAIN_D,   32'h0001_0000, 0,      0,      0, 0},
        '{0, REG_GAIN_P,   0,             5,      0,      0, 0},
        '{0, REG_GAIN_P,   0,             -5,     0,      0, 0},
        '{1, REG_GAIN_D,   0,             0,      0,      0, 0},
        '{1, REG_GAIN_I,   32'h0001_0000, 0,      0,      0, 0},
        '{0, REG_GAIN_P,   0,             10,     0,      0, 0},
        '{0, REG_GAIN_P,   0,             20,     -20,    0, 0},
        '{1, REG_SEP_ON,   1,             0,      0,      0, 0},
        '{0, REG_GAIN_P,   0,             10,     0,      0, 0},
        '{1, REG_SEP_THR,  50,            0,      0,      0, 0},
        '{0, REG_GAIN_P,   0,             49,     0,      0, 0},
        '{0, REG_GAIN_P,   0,             50,     0,      0, 0},
        '{0, REG_GAIN_P,   0,             0,      49,     0, 0},
        '{0, REG_GAIN_P,   0,             -25,    25,     0, 0},
        '{1, REG_INT_LIM,  0,             0,      0,      0, 0},
        '{0, REG_GAIN_P,   0,             30,     0,      0, 0},
        '{1, REG_POS_MODE, 0,             0,      0,      0, 0},
        '{0, REG_GAIN_P,   0,             1000,   -1000,  1, 0},
        '{0, REG_GAIN_P,   0,             -7,     5,      1, 0},
        '{1, REG_POS_MODE, 1,             0,      0,      0, 0},
        '{1, REG_GAIN_D,   32'h7FFF_FFFF, 0,      0,      0, 0},
        '{0, REG_GAIN_P,   0,             0,      0,      0, 0}
    };

    pid_integral_separation #(
        .FRAC_BITS        (FRAC_BITS)
    ) i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_target_value   (i_target_value),
        .i_measured_value (i_measured_value),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_drive_value    (o_drive_value),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_data       (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic longint clamp_sym(longint x, longint lim);
        if (x > lim) return lim;
        if (x < -lim) return -lim;
        return x;
    endfunction

    // one controller step; updates error history and, in positional mode, the integral
    function automatic logic [OUT_W-1:0] predict_drive(logic signed [IN_W-1:0] tgt,
                                                       logic signed [IN_W-1:0] meas);
        longint err, prev, mag, p_term, d_term, total;
        err      = longint'(tgt) - longint'(meas);
        prev     = err_hist;
        err_hist = err;
        if (!cfg_mirror.pos_mode) return '0;
        mag    = (err < 0) ? -err : err;
        p_term = longint'($signed(cfg_mirror.gain_p)) * err;
        d_term = longint'($signed(cfg_mirror.gain_d)) * (err - prev);
        if (!cfg_mirror.sep_on || mag < longint'(cfg_mirror.sep_thr))
            integ_acc += longint'($signed(cfg_mirror.gain_i)) * err;
        integ_acc = clamp_sym(integ_acc, longint'(cfg_mirror.int_lim) << FRAC_BITS);
        total = clamp_sym(p_term + integ_acc + d_term,
                          longint'(cfg_mirror.out_lim) << FRAC_BITS);
        return OUT_W'(total / (longint'(1) << FRAC_BITS));
    endfunction

    function automatic int pick_gap();
        int r;
        if (tx_calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    function automatic logic [GAIN_W-1:0] rand_gain();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return $urandom;
        if (r < 20) return '0;
        return GAIN_W'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
    endfunction

    function automatic logic [LIM_W-1:0] rand_limit();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return '0;
        if (r < 25) return 15'h7FFF;
        if (r < 70) return LIM_W'($urandom_range(0, 2000));
        return LIM_W'($urandom);
    endfunction

    function automatic t_cfg rand_cfg(int flavour);
        t_cfg c;
        int   r;
        c.gain_p  = rand_gain();
        c.gain_i  = rand_gain();
        c.gain_d  = rand_gain();
        c.int_lim = rand_limit();
        c.out_lim = rand_limit();
        r = $urandom_range(0, 99);
        if (r < 15)      c.sep_thr = '0;
        else if (r < 25) c.sep_thr = 16'hFFFF;
        else if (r < 75) c.sep_thr = THR_W'($urandom_range(0, 300));
        else             c.sep_thr = THR_W'($urandom);
        c.sep_on   = 1'($urandom_range(0, 1));
        c.pos_mode = ($urandom_range(0, 9) != 0);
        if (flavour == 0) begin
            c.gain_p   = 32'h7FFF_FFFF;
            c.gain_i   = 32'h8000_0000;
            c.gain_d   = 32'h7FFF_FFFF;
            c.int_lim  = 15'h7FFF;
            c.out_lim  = 15'h7FFF;
            c.sep_thr  = 16'hFFFF;
            c.sep_on   = 1'b1;
            c.pos_mode = 1'b1;
        end else if (flavour == 1) begin
            c.int_lim  = '0;
            c.out_lim  = '0;
            c.pos_mode = 1'b1;
        end
        return c;
    endfunction

    task automatic write_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_GAIN_P:   cfg_mirror.gain_p   = val;
            REG_GAIN_I:   cfg_mirror.gain_i   = val;
            REG_GAIN_D:   cfg_mirror.gain_d   = val;
            REG_INT_LIM:  cfg_mirror.int_lim  = val[LIM_W-1:0];
            REG_OUT_LIM:  cfg_mirror.out_lim  = val[LIM_W-1:0];
            REG_SEP_THR:  cfg_mirror.sep_thr  = val[THR_W-1:0];
            REG_SEP_ON:   cfg_mirror.sep_on   = val[0];
            REG_POS_MODE: cfg_mirror.pos_mode = val[0];
            default: ;
        endcase
    endtask

    // upper bits carry noise: the block must mask them
    task automatic apply_config(t_cfg c);
        write_reg(REG_GAIN_P,   c.gain_p);
        write_reg(REG_GAIN_I,   c.gain_i);
        write_reg(REG_GAIN_D,   c.gain_d);
        write_reg(REG_INT_LIM,  {17'($urandom), c.int_lim});
        write_reg(REG_OUT_LIM,  {17'($urandom), c.out_lim});
        write_reg(REG_SEP_THR,  {16'($urandom), c.sep_thr});
        write_reg(REG_SEP_ON,   {31'($urandom), c.sep_on});
        write_reg(REG_POS_MODE, {31'($urandom), c.pos_mode});
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (drive_expected_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic push_sample(logic signed [IN_W-1:0] tgt, logic signed [IN_W-1:0] meas,
                               bit typed, logic [OUT_W-1:0] want);
        int gap;
        bit taken;
        logic [OUT_W-1:0] pred;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_target_value   <= tgt;
        i_measured_value <= meas;
        do begin
            @(negedge i_clk);
            taken = !o_stall;
            @(posedge i_clk);
        end while (!taken);
        pred = predict_drive(tgt, meas);
        drive_expected_q.push_back(typed ? want : pred);
    endtask

    // receiver stall: mostly free, short bursts, now and then a long hold
    always @(posedge i_clk) begin
        if (!i_rst_n || rx_calm) begin
            i_stall    <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            i_stall    <= 1'b1;
            stall_left <= stall_left - 1;
        end else begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4:   begin
                    i_stall    <= 1'b1;
                    stall_left <= $urandom_range(0, 2);
                end
                5:       begin
                    i_stall    <= 1'b1;
                    stall_left <= $urandom_range(4, 30);
                end
                default: i_stall <= 1'b0;
            endcase
        end
    end

    // outputs are steady at the falling edge; a transfer follows at the next rise
    always @(negedge i_clk) begin : drive_check
        logic [OUT_W-1:0] want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (drive_expected_q.size() == 0) begin
                $error("drive_value: transfer with nothing expected, actual %0d",
                       $signed(o_drive_value));
                fail_count++;
            end else begin
                want = drive_expected_q.pop_front();
                if (o_drive_value !== want) begin
                    $error("drive_value mismatch: expected %0d, actual %0d",
                           $signed(want), $signed(o_drive_value));
                    fail_count++;
                end
            end
        end
    end

    initial begin
        logic signed [IN_W-1:0] tgt, meas;
        int delta, m, pause_at, r;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        foreach (directed_plan[k]) begin
            if (directed_plan[k].is_cfg) begin
                wait_idle();
                write_reg(directed_plan[k].idx, directed_plan[k].data);
            end else begin
                push_sample(IN_W'(directed_plan[k].tgt), IN_W'(directed_plan[k].meas),
                            directed_plan[k].typed, OUT_W'(directed_plan[k].want));
            end
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            wait_idle();
            tx_calm <= (ph % 4 == 2);
            rx_calm <= (ph % 4 == 3);
            apply_config(rand_cfg(ph == 0 ? 0 : (ph == 5 ? 1 : 2)));
            pause_at = $urandom_range(10, PHASE_LEN - 10);
            for (int n = 0; n < PHASE_LEN; n++) begin
                if (n == pause_at) wait_idle();
                tgt = IN_W'($urandom);
                r   = $urandom_range(0, 9);
                if (r < 3) begin
                    meas = IN_W'($urandom);
                end else begin
                    // small errors, or errors right at the separation threshold
                    if (r < 6) delta = $urandom_range(0, 600) - 300;
                    else       delta = int'(cfg_mirror.sep_thr) + $urandom_range(0, 2) - 1;
                    if ($urandom_range(0, 1)) delta = -delta;
                    m = int'(tgt) - delta;
                    if (m > 32767)  m = 32767;
                    if (m < -32768) m = -32768;
                    meas = IN_W'(m);
                end
                push_sample(tgt, meas, 1'b0, '0);
            end
        end

        wait_idle();
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
